// ===== rtl/sstcp_pkg.sv =====
// Shared types, character codes and lookup tables for the console command parser.
// Used by serial_settime_command_parser and sstcp_scanner; depends on nothing else.
package sstcp_pkg;

    // Command kinds reported on the result channel
    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_TIME  = 3'd1;
    localparam logic [2:0] CMD_HELP  = 3'd2;
    localparam logic [2:0] CMD_UNK   = 3'd3;
    localparam logic [2:0] CMD_USAGE = 3'd4;

    // Console characters
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int          MAG_W    = 14;
    localparam logic [13:0] NUM_SAT  = 14'd9999;
    localparam logic [13:0] YEAR_MIN = 14'd2000;
    localparam logic [13:0] YEAR_MAX = 14'd2099;

    // Result of scanning one line, held by the scanner after the end marker
    typedef struct packed {
        logic                   kw_set;   // line starts with SETTIME, any case
        logic                   kw_time;  // line starts with TIME, any case
        logic                   kw_help;  // line starts with HELP, any case
        logic                   parse_ok; // six numbers read per the pattern
        logic [5:0]             neg_nz;   // number was negative and nonzero
        logic [5:0][MAG_W-1:0]  mag;      // saturated magnitudes
    } t_scan_res;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'h09 && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [7:0] settime_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = 8'h53; // S
            3'd1:    r = 8'h45; // E
            3'd2:    r = 8'h54; // T
            3'd3:    r = 8'h54; // T
            3'd4:    r = 8'h49; // I
            3'd5:    r = 8'h4D; // M
            3'd6:    r = 8'h45; // E
            default: r = CHAR_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] time_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0:    r = 8'h54; // T
            2'd1:    r = 8'h49; // I
            2'd2:    r = 8'h4D; // M
            default: r = 8'h45; // E
        endcase
        return r;
    endfunction

    function automatic logic [7:0] help_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0:    r = 8'h48; // H
            2'd1:    r = 8'h45; // E
            2'd2:    r = 8'h4C; // L
            default: r = 8'h50; // P
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd2:                      r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    // Weekday offset per month for the day-of-week sum
    function automatic logic [2:0] wd_offset(input logic [3:0] m);
        logic [2:0] r;
        unique case (m)
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sstcp_scanner.sv =====
// Character-serial scanner: keyword prefixes and the SETTIME number pattern.
// Takes one character per valid cycle after a start pulse; uses sstcp_pkg.
module sstcp_scanner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_chr_valid,
    input  logic [7:0]            i_chr,
    output sstcp_pkg::t_scan_res  o_res
);

    typedef enum logic [2:0] {
        SC_LIT, SC_WS, SC_SIGN, SC_DIG, SC_OK, SC_FAIL
    } t_scan_state;

    t_scan_state                         r_state, n_state;
    logic [2:0]                          r_pos, n_pos;
    logic [2:0]                          r_idx, n_idx;
    logic [sstcp_pkg::MAG_W-1:0]         r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic                                r_kw_set, n_kw_set;
    logic                                r_kw_time, n_kw_time;
    logic                                r_kw_help, n_kw_help;
    logic [5:0][sstcp_pkg::MAG_W-1:0]    r_vals, n_vals;
    logic [5:0]                          r_neg_nz, n_neg_nz;

    logic [7:0]                          lc;
    logic [3:0]                          dig;
    logic [16:0]                         acc;
    t_scan_state                         st_state;
    logic                                st_neg;
    logic [7:0]                          sep;

    always_comb begin
        lc  = sstcp_pkg::to_lower(i_chr);
        dig = i_chr[3:0];
        acc = ({3'b0, r_mag} << 3) + ({3'b0, r_mag} << 1) + {13'b0, dig};

        // Outcome of a character seen where a number may begin
        st_neg = 1'b0;
        if (sstcp_pkg::is_space(i_chr)) begin
            st_state = SC_WS;
        end else if (i_chr == sstcp_pkg::CHAR_PLUS || i_chr == sstcp_pkg::CHAR_MINUS) begin
            st_state = SC_SIGN;
            st_neg   = (i_chr == sstcp_pkg::CHAR_MINUS);
        end else if (sstcp_pkg::is_digit(i_chr)) begin
            st_state = SC_DIG;
        end else begin
            st_state = SC_FAIL;
        end

        sep = (r_idx < 3'd2) ? sstcp_pkg::CHAR_MINUS : sstcp_pkg::CHAR_COLON;

        n_state   = r_state;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_kw_set  = r_kw_set;
        n_kw_time = r_kw_time;
        n_kw_help = r_kw_help;
        n_vals    = r_vals;
        n_neg_nz  = r_neg_nz;

        if (i_chr_valid) begin
            // Case-insensitive prefix tracking
            if (r_pos != 3'd7) begin
                n_pos = r_pos + 3'd1;
                if (lc != sstcp_pkg::to_lower(sstcp_pkg::settime_char(r_pos))) begin
                    n_kw_set = 1'b0;
                end
            end
            if (r_pos < 3'd4) begin
                if (lc != sstcp_pkg::to_lower(sstcp_pkg::time_char(r_pos[1:0]))) begin
                    n_kw_time = 1'b0;
                end
                if (lc != sstcp_pkg::to_lower(sstcp_pkg::help_char(r_pos[1:0]))) begin
                    n_kw_help = 1'b0;
                end
            end

            unique case (r_state)
                SC_LIT: begin
                    if (i_chr != sstcp_pkg::settime_char(r_pos)) begin
                        n_state = SC_FAIL;
                    end else if (r_pos == 3'd6) begin
                        n_state = SC_WS;
                        n_idx   = 3'd0;
                    end
                end
                SC_WS: begin
                    n_state = st_state;
                    n_neg   = st_neg;
                    n_mag   = {10'b0, dig};
                end
                SC_SIGN: begin
                    if (sstcp_pkg::is_digit(i_chr)) begin
                        n_state = SC_DIG;
                        n_mag   = {10'b0, dig};
                    end else begin
                        n_state = SC_FAIL;
                    end
                end
                SC_DIG: begin
                    if (sstcp_pkg::is_digit(i_chr)) begin
                        n_mag = (acc > {3'b0, sstcp_pkg::NUM_SAT}) ? sstcp_pkg::NUM_SAT
                                                                   : acc[13:0];
                    end else begin
                        // Commit the number, then handle its separator
                        n_vals[r_idx]   = r_mag;
                        n_neg_nz[r_idx] = r_neg && (r_mag != '0);
                        if (r_idx == 3'd5) begin
                            n_state = SC_OK;
                        end else if (r_idx == 3'd2) begin
                            // Date and time part with no literal between them
                            n_idx   = r_idx + 3'd1;
                            n_state = st_state;
                            n_neg   = st_neg;
                        end else if (i_chr == sep) begin
                            n_idx   = r_idx + 3'd1;
                            n_state = SC_WS;
                        end else begin
                            n_state = SC_FAIL;
                        end
                    end
                end
                SC_OK, SC_FAIL: begin
                    n_state = r_state;
                end
                default: n_state = SC_FAIL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SC_FAIL;
            r_pos     <= '0;
            r_idx     <= '0;
            r_kw_set  <= 1'b0;
            r_kw_time <= 1'b0;
            r_kw_help <= 1'b0;
        end else if (i_start) begin
            r_state   <= SC_LIT;
            r_pos     <= '0;
            r_idx     <= '0;
            r_kw_set  <= 1'b1;
            r_kw_time <= 1'b1;
            r_kw_help <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_idx     <= n_idx;
            r_kw_set  <= n_kw_set;
            r_kw_time <= n_kw_time;
            r_kw_help <= n_kw_help;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_vals   <= n_vals;
        r_neg_nz <= n_neg_nz;
    end

    assign o_res.kw_set   = r_kw_set;
    assign o_res.kw_time  = r_kw_time;
    assign o_res.kw_help  = r_kw_help;
    assign o_res.parse_ok = (r_state == SC_OK);
    assign o_res.neg_nz   = r_neg_nz;
    assign o_res.mag      = r_vals;

endmodule

// ===== rtl/serial_settime_command_parser.sv =====
// Serial console line editor and SETTIME / TIME / HELP command classifier.
// Sequence: a non-empty line end starts a scan of the L characters up to the line length or the
// first zero byte; ST_FIN registers the check, ST_DONE loads the request. Throughput: one byte
// per cycle while editing; a non-empty line end blocks input through scan, check and output,
// longer while the previous request still waits. Reset (synchronous, active low) empties the
// line and the output register; the line memory is not cleared, only current entries are read.
module serial_settime_command_parser #(
    parameter int LINE_CAPACITY = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [2:0] cmd_kind, [14:3] year, [18:15] month,
                                        // [23:19] day, [26:24] weekday, [31:27] hour,
                                        // [37:32] minute, [43:38] second, rest zero
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

    typedef enum logic [1:0] {
        ST_IDLE, ST_SCAN, ST_FIN, ST_DONE
    } t_state;

    t_state                r_state;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_addr;
    logic                  r_rd_vld;
    logic                  r_rd_end;
    logic [7:0]            r_rd_data;
    logic [7:0]            r_mem [LINE_CAPACITY];

    // Checked result, held between the check cycle and the output register
    logic [2:0]            r_kind;
    logic [11:0]           r_wsum;
    logic [11:0]           r_year;
    logic [3:0]            r_month;
    logic [4:0]            r_day;
    logic [4:0]            r_hour;
    logic [5:0]            r_minute;
    logic [5:0]            r_second;

    logic                  r_m_valid;
    logic [47:0]           r_m_data;

    logic                  in_acc;
    logic                  is_eol;
    logic                  is_erase;
    logic                  do_append;
    logic                  scan_start;
    logic                  out_load;
    logic [7:0]            chr;
    logic                  chr_valid;
    sstcp_pkg::t_scan_res  scan_res;

    // Check-cycle signals
    logic                  year_ok, month_ok, day_ok, time_ok, set_ok;
    logic [4:0]            max_day;
    logic [11:0]           y_adj;
    logic [11:0]           wsum;
    logic [2:0]            n_kind;

    // Weekday fold: 8 = 1 mod 7, so add octal digits
    logic [4:0]            fold1;
    logic [3:0]            fold2;
    logic [2:0]            weekday;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign is_eol     = (s_axis_tdata == sstcp_pkg::CHAR_CR) ||
                        (s_axis_tdata == sstcp_pkg::CHAR_LF);
    assign is_erase   = (s_axis_tdata == sstcp_pkg::CHAR_BS) ||
                        (s_axis_tdata == sstcp_pkg::CHAR_DEL);
    assign do_append  = in_acc && !is_eol && !is_erase && (r_len < LEN_MAX);
    assign scan_start = in_acc && is_eol && (r_len != '0);
    // Load the output register once it is free or being drained
    assign out_load   = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // A read issued at the line length stands for the end marker
    assign chr       = r_rd_end ? sstcp_pkg::CHAR_NUL : r_rd_data;
    assign chr_valid = (r_state == ST_SCAN) && r_rd_vld;

    sstcp_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start),
        .i_chr_valid (chr_valid),
        .i_chr       (chr),
        .o_res       (scan_res)
    );

    // Line memory: write on append, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_mem[r_len] <= s_axis_tdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Range checks and the weekday sum over the scanned numbers
    always_comb begin
        year_ok  = !scan_res.neg_nz[0] &&
                   scan_res.mag[0] >= sstcp_pkg::YEAR_MIN &&
                   scan_res.mag[0] <= sstcp_pkg::YEAR_MAX;
        month_ok = !scan_res.neg_nz[1] &&
                   scan_res.mag[1] >= 14'd1 && scan_res.mag[1] <= 14'd12;
        // Inside 2000..2099 a year is leap exactly when divisible by four
        max_day  = sstcp_pkg::month_days(scan_res.mag[1][3:0]);
        if (scan_res.mag[1][3:0] == 4'd2 && scan_res.mag[0][1:0] == 2'b00) begin
            max_day = 5'd29;
        end
        day_ok   = !scan_res.neg_nz[2] &&
                   scan_res.mag[2] >= 14'd1 && scan_res.mag[2] <= {9'b0, max_day};
        time_ok  = (scan_res.neg_nz[5:3] == 3'b000) &&
                   scan_res.mag[3] <= 14'd23 &&
                   scan_res.mag[4] <= 14'd59 &&
                   scan_res.mag[5] <= 14'd59;
        set_ok   = scan_res.parse_ok && year_ok && month_ok && day_ok && time_ok;

        // January and February count in the previous year; the century terms
        // give -15 for every year 1999..2099
        y_adj = scan_res.mag[0][11:0] -
                ((scan_res.mag[1][3:0] < 4'd3) ? 12'd1 : 12'd0);
        wsum  = y_adj + (y_adj >> 2) - 12'd15 +
                {9'b0, sstcp_pkg::wd_offset(scan_res.mag[1][3:0])} +
                {7'b0, scan_res.mag[2][4:0]};

        priority if (scan_res.kw_set) begin
            n_kind = set_ok ? sstcp_pkg::CMD_SET : sstcp_pkg::CMD_USAGE;
        end else if (scan_res.kw_time) begin
            n_kind = sstcp_pkg::CMD_TIME;
        end else if (scan_res.kw_help) begin
            n_kind = sstcp_pkg::CMD_HELP;
        end else begin
            n_kind = sstcp_pkg::CMD_UNK;
        end
    end

    always_comb begin
        fold1   = {2'b0, r_wsum[2:0]} + {2'b0, r_wsum[5:3]} +
                  {2'b0, r_wsum[8:6]} + {2'b0, r_wsum[11:9]};
        fold2   = {1'b0, fold1[2:0]} + {2'b0, fold1[4:3]};
        weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    end

    // Line control, scan sequencing and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_end  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (is_eol) begin
                            // Empty line ends give no request
                            if (r_len != '0) begin
                                r_state  <= ST_SCAN;
                                r_addr   <= '0;
                                r_rd_vld <= 1'b0;
                            end
                        end else if (is_erase) begin
                            if (r_len != '0) begin
                                r_len <= r_len - 1'b1;
                            end
                        end else if (r_len < LEN_MAX) begin
                            r_len <= r_len + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_rd_vld && chr == sstcp_pkg::CHAR_NUL) begin
                        r_state  <= ST_FIN;
                        r_rd_vld <= 1'b0;
                    end else begin
                        // Advance the read pointer, holding it at the end marker
                        r_rd_vld <= 1'b1;
                        r_rd_end <= (r_addr == r_len);
                        if (r_addr != r_len) begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    r_state  <= ST_DONE;
                    r_kind   <= n_kind;
                    r_wsum   <= wsum;
                    r_year   <= scan_res.mag[0][11:0];
                    r_month  <= scan_res.mag[1][3:0];
                    r_day    <= scan_res.mag[2][4:0];
                    r_hour   <= scan_res.mag[3][4:0];
                    r_minute <= scan_res.mag[4][5:0];
                    r_second <= scan_res.mag[5][5:0];
                end
                ST_DONE: begin
                    // Wait for the output register to free up
                    if (out_load) begin
                        if (r_kind == sstcp_pkg::CMD_SET) begin
                            r_m_data <= {4'b0, r_second, r_minute, r_hour, weekday,
                                         r_day, r_month, r_year, r_kind};
                        end else begin
                            r_m_data <= {45'b0, r_kind};
                        end
                        r_len   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A non-empty line end must hand the line to the scan and stop input
    a_eol_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_start |=> (r_state == ST_SCAN) && !s_axis_tready)
        else $error("line end did not start a scan");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length beyond capacity");

    a_set_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == sstcp_pkg::CMD_SET) |->
        (m_axis_tdata[26:24] <= 3'd6) && (m_axis_tdata[18:15] >= 4'd1) &&
        (m_axis_tdata[18:15] <= 4'd12) && (m_axis_tdata[23:19] != 5'd0))
        else $error("accepted set time has out-of-range fields");

    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != sstcp_pkg::CMD_SET) |->
        (m_axis_tdata[47:3] == 45'b0))
        else $error("non set-time result carries field data");

endmodule
